@@ rtl/serial_camera_image_fetch_unit_assert.svh @@
// Assertion macros for the serial camera image fetch unit.
// No dependencies; included by the top level only.
`ifndef SERIAL_CAMERA_IMAGE_FETCH_UNIT_ASSERT_SVH
`define SERIAL_CAMERA_IMAGE_FETCH_UNIT_ASSERT_SVH

// same-cycle implication
`define SCIF_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("scif: same-cycle check failed");

// next-cycle implication
`define SCIF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("scif: next-cycle check failed");

`endif

@@ rtl/scif_pkg.sv @@
// Shared types, codes and byte constants of the serial camera image fetch unit.
// No dependencies.
package scif_pkg;

   // input operation codes
   localparam logic [1:0] OP_START = 2'd0;
   localparam logic [1:0] OP_BYTE  = 2'd1;
   localparam logic [1:0] OP_TICK  = 2'd2;

   // result kinds
   localparam logic [1:0] KIND_CMD   = 2'd0;
   localparam logic [1:0] KIND_IMAGE = 2'd1;
   localparam logic [1:0] KIND_DONE  = 2'd2;
   localparam logic [1:0] KIND_FAIL  = 2'd3;

   // register indexes
   localparam logic [1:0] REG_CAMERA_ID     = 2'd0;
   localparam logic [1:0] REG_RESOLUTION    = 2'd1;
   localparam logic [1:0] REG_ACK_TIMEOUT   = 2'd2;
   localparam logic [1:0] REG_IMAGE_TIMEOUT = 2'd3;

   // protocol bytes
   localparam logic [7:0] SYNC_BYTE = 8'h55;
   localparam logic [7:0] SNAP_CMD  = 8'h48;
   localparam logic [7:0] PKG_CMD   = 8'h45;
   localparam logic [7:0] INFO_TAG  = 8'h52;
   localparam logic [7:0] SNAP_ARG  = 8'h04;
   localparam logic [7:0] TAIL_BYTE = 8'h23;
   localparam logic [7:0] NUL_BYTE  = 8'h00;

   typedef enum logic [2:0] {
      BURST_NONE,
      BURST_SNAP,
      BURST_REQ,
      BURST_IMAGE,
      BURST_DONE,
      BURST_FAIL
   } burst_type;

   typedef struct packed {
      logic [7:0]  camera_id;
      logic [7:0]  resolution_code;
      logic [15:0] ack_timeout;
      logic [15:0] img_limit;
   } cfg_type;

   // one burst of results, handed from the core to the transmitter
   typedef struct packed {
      burst_type   burst;
      logic [7:0]  camera_id;
      logic [7:0]  resolution_code;
      logic [15:0] number;
      logic [7:0]  data;
      logic [14:0] offset;
      logic [14:0] size;
      logic [9:0]  total;
   } desc_type;

   function automatic logic [7:0] snap_ack_byte(input logic [1:0] idx);
      logic [7:0] b;
      case (idx)
         2'd0:    b = SYNC_BYTE;
         2'd1:    b = SNAP_CMD;
         2'd2:    b = NUL_BYTE;
         default: b = TAIL_BYTE;
      endcase
      return b;
   endfunction

   function automatic logic [7:0] pkg_ack_byte(input logic [1:0] idx);
      logic [7:0] b;
      case (idx)
         2'd0:    b = SYNC_BYTE;
         2'd1:    b = PKG_CMD;
         2'd2:    b = NUL_BYTE;
         default: b = TAIL_BYTE;
      endcase
      return b;
   endfunction

endpackage

@@ rtl/scif_csr.sv @@
// APB-style register file: camera id, resolution, ack and image timeouts.
// Depends on scif_pkg.
module scif_csr import scif_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   output cfg_type     cfg
);

   cfg_type cfg_ff, cfg_in;
   logic    wr_en;
   logic [1:0] reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = paddr[3:2];
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_CAMERA_ID:     cfg_in.camera_id       = pwdata[7:0];
            REG_RESOLUTION:    cfg_in.resolution_code = pwdata[7:0];
            REG_ACK_TIMEOUT:   cfg_in.ack_timeout     = pwdata[15:0];
            REG_IMAGE_TIMEOUT: cfg_in.img_limit       = pwdata[15:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_CAMERA_ID:     prdata = {24'd0, cfg_ff.camera_id};
         REG_RESOLUTION:    prdata = {24'd0, cfg_ff.resolution_code};
         REG_ACK_TIMEOUT:   prdata = {16'd0, cfg_ff.ack_timeout};
         REG_IMAGE_TIMEOUT: prdata = {16'd0, cfg_ff.img_limit};
         default:           prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.camera_id       <= 8'd0;
         cfg_ff.resolution_code <= 8'd50;
         cfg_ff.ack_timeout     <= 16'd50;
         cfg_ff.img_limit       <= 16'd100;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ rtl/scif_core.sv @@
// Capture sequencer: phase state, frame checks, timers and burst selection.
// Depends on scif_pkg.
module scif_core import scif_pkg::*; #(
   parameter int PAYLOAD_BYTES   = 1024,
   parameter int MAX_IMAGE_BYTES = 32768,
   parameter int COUNT_WRAP      = 1000
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [1:0] operation,
   input  logic [7:0] rx_byte,
   input  cfg_type    cfg,
   output desc_type   desc
);

   localparam int FI_W   = $clog2(PAYLOAD_BYTES + 10);
   localparam int PLEN_W = $clog2(PAYLOAD_BYTES + 1);
   localparam int FULL_W = 16 + PLEN_W;

   localparam logic [2:0] PH_IDLE     = 3'd0;
   localparam logic [2:0] PH_SNAP_ACK = 3'd1;
   localparam logic [2:0] PH_INFO     = 3'd2;
   localparam logic [2:0] PH_PKG_ACK  = 3'd3;
   localparam logic [2:0] PH_PKG_DATA = 3'd4;

   logic [2:0]        phase_ff, phase_in;
   logic [FI_W-1:0]   fi_ff, fi_in;
   logic [15:0]       size_ff, size_in;
   logic [15:0]       count_ff, count_in;
   logic [16:0]       num_ff, num_in;
   logic [15:0]       woff_ff, woff_in;
   logic [15:0]       wait_ff, wait_in;
   logic [15:0]       img_ff, img_in;
   logic [9:0]        cap_ff, cap_in;
   logic              ok_ff, ok_in;
   logic              high_ff, high_in;
   logic [FULL_W-1:0] full_ff, full_in;
   logic [PLEN_W-1:0] plen_ff, plen_in;

   logic [FI_W-1:0]   fi_inc;
   logic [FI_W-1:0]   plen_ext;
   logic [15:0]       wait_inc, img_inc;
   logic [16:0]       num_inc;
   logic              ok_v;
   logic [FULL_W-1:0] size_ext, rem;

   assign fi_inc   = fi_ff + FI_W'(1);
   assign plen_ext = FI_W'(plen_ff);
   assign wait_inc = (wait_ff == 16'hFFFF) ? wait_ff : wait_ff + 16'd1;
   assign img_inc  = (img_ff == 16'hFFFF) ? img_ff : img_ff + 16'd1;
   assign num_inc  = num_ff + 17'd1;
   assign size_ext = FULL_W'(size_ff);
   assign rem      = size_ext - full_ff;

   // payload length of the current package, two register stages behind the
   // frame state; it settles long before the first payload byte arrives
   always_comb begin
      full_in = (count_ff == 16'd0) ? '0
              : FULL_W'(count_ff - 16'd1) * FULL_W'(PAYLOAD_BYTES);
      if (num_ff < {1'b0, count_ff}) begin
         plen_in = PLEN_W'(PAYLOAD_BYTES);
      end else if (size_ext <= full_ff) begin
         plen_in = '0;
      end else if (rem > FULL_W'(PAYLOAD_BYTES)) begin
         plen_in = PLEN_W'(PAYLOAD_BYTES);
      end else begin
         plen_in = rem[PLEN_W-1:0];
      end
   end

   always_comb begin
      phase_in = phase_ff;
      fi_in    = fi_ff;
      size_in  = size_ff;
      count_in = count_ff;
      num_in   = num_ff;
      woff_in  = woff_ff;
      wait_in  = wait_ff;
      img_in   = img_ff;
      cap_in   = cap_ff;
      ok_in    = ok_ff;
      high_in  = high_ff;
      ok_v     = ok_ff;

      desc.burst           = BURST_NONE;
      desc.camera_id       = cfg.camera_id;
      desc.resolution_code = cfg.resolution_code;
      desc.number          = num_ff[15:0];
      desc.data            = rx_byte;
      desc.offset          = woff_ff[14:0];
      desc.size            = size_ff[14:0];
      desc.total           = cap_ff + 10'd1;

      case (operation)
         OP_START: begin
            cap_in     = (cap_ff > 10'(COUNT_WRAP)) ? 10'd0 : cap_ff;
            desc.burst = BURST_SNAP;
            phase_in   = PH_SNAP_ACK;
            fi_in      = '0;
            wait_in    = 16'd0;
            img_in     = 16'd0;
            ok_in      = 1'b1;
         end
         OP_BYTE: begin
            unique case (phase_ff)
               PH_SNAP_ACK: begin
                  ok_v  = ok_ff && (rx_byte == snap_ack_byte(fi_ff[1:0]));
                  ok_in = ok_v;
                  fi_in = fi_inc;
                  if (fi_inc >= FI_W'(4)) begin
                     if (!ok_v) begin
                        desc.burst = BURST_FAIL;
                        phase_in   = PH_IDLE;
                     end else begin
                        phase_in = PH_INFO;
                        fi_in    = '0;
                        ok_in    = 1'b1;
                        high_in  = 1'b0;
                        size_in  = 16'd0;
                        count_in = 16'd0;
                     end
                  end
               end
               PH_INFO: begin
                  case (fi_ff)
                     FI_W'(0): ok_in = ok_ff && (rx_byte == SYNC_BYTE);
                     FI_W'(1): ok_in = ok_ff && (rx_byte == INFO_TAG);
                     FI_W'(3): size_in = {8'd0, rx_byte};
                     FI_W'(4): size_in = {rx_byte, size_ff[7:0]};
                     FI_W'(5): high_in = high_ff || (rx_byte != NUL_BYTE);
                     FI_W'(6): high_in = high_ff || (rx_byte != NUL_BYTE);
                     FI_W'(7): count_in = {8'd0, rx_byte};
                     FI_W'(8): count_in = {rx_byte, count_ff[7:0]};
                     default: ;
                  endcase
                  fi_in = fi_inc;
                  // the tenth byte changes nothing, so the held values decide
                  if (fi_inc >= FI_W'(10)) begin
                     if (!ok_ff || high_ff || size_ff == 16'd0 ||
                         {1'b0, size_ff} >= 17'(MAX_IMAGE_BYTES)) begin
                        desc.burst = BURST_FAIL;
                        phase_in   = PH_IDLE;
                     end else begin
                        num_in  = 17'd1;
                        woff_in = 16'd0;
                        img_in  = 16'd0;
                        if (count_ff == 16'd0) begin
                           cap_in     = cap_ff + 10'd1;
                           desc.burst = BURST_DONE;
                           phase_in   = PH_IDLE;
                        end else begin
                           desc.burst  = BURST_REQ;
                           desc.number = 16'd1;
                           phase_in    = PH_PKG_ACK;
                           fi_in       = '0;
                           wait_in     = 16'd0;
                           ok_in       = 1'b1;
                        end
                     end
                  end
               end
               PH_PKG_ACK: begin
                  ok_v  = ok_ff && (rx_byte == pkg_ack_byte(fi_ff[1:0]));
                  ok_in = ok_v;
                  fi_in = fi_inc;
                  if (fi_inc >= FI_W'(4)) begin
                     if (ok_v) begin
                        phase_in = PH_PKG_DATA;
                        fi_in    = '0;
                     end else if (img_ff > cfg.img_limit) begin
                        desc.burst = BURST_FAIL;
                        phase_in   = PH_IDLE;
                     end else begin
                        // wait for a fresh ack, no resend
                        fi_in   = '0;
                        wait_in = 16'd0;
                        ok_in   = 1'b1;
                     end
                  end
               end
               PH_PKG_DATA: begin
                  if (fi_ff >= FI_W'(7) && fi_ff < FI_W'(7) + plen_ext &&
                      woff_ff < size_ff) begin
                     desc.burst = BURST_IMAGE;
                     woff_in    = woff_ff + 16'd1;
                  end
                  fi_in = fi_inc;
                  if (fi_inc >= plen_ext + FI_W'(9)) begin
                     num_in = num_inc;
                     if (num_inc > {1'b0, count_ff}) begin
                        cap_in     = cap_ff + 10'd1;
                        desc.burst = BURST_DONE;
                        phase_in   = PH_IDLE;
                     end else begin
                        desc.burst  = BURST_REQ;
                        desc.number = num_inc[15:0];
                        phase_in    = PH_PKG_ACK;
                        fi_in       = '0;
                        wait_in     = 16'd0;
                        ok_in       = 1'b1;
                     end
                  end
               end
               default: ;
            endcase
         end
         OP_TICK: begin
            if (phase_ff == PH_SNAP_ACK) begin
               if (fi_ff == '0) begin
                  wait_in = wait_inc;
                  if (wait_inc > cfg.ack_timeout) begin
                     desc.burst = BURST_FAIL;
                     phase_in   = PH_IDLE;
                  end
               end
            end else if (phase_ff == PH_PKG_ACK || phase_ff == PH_PKG_DATA) begin
               img_in = img_inc;
               if (phase_ff == PH_PKG_ACK && fi_ff == '0) begin
                  wait_in = wait_inc;
                  if (wait_inc > cfg.ack_timeout) begin
                     wait_in = 16'd0;
                     if (img_inc > cfg.img_limit) begin
                        desc.burst = BURST_FAIL;
                        phase_in   = PH_IDLE;
                     end
                  end
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      full_ff <= full_in;
      plen_ff <= plen_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         fi_ff    <= '0;
         size_ff  <= 16'd0;
         count_ff <= 16'd0;
         num_ff   <= 17'd0;
         woff_ff  <= 16'd0;
         wait_ff  <= 16'd0;
         img_ff   <= 16'd0;
         cap_ff   <= 10'd0;
         ok_ff    <= 1'b0;
         high_ff  <= 1'b0;
      end else if (step) begin
         phase_ff <= phase_in;
         fi_ff    <= fi_in;
         size_ff  <= size_in;
         count_ff <= count_in;
         num_ff   <= num_in;
         woff_ff  <= woff_in;
         wait_ff  <= wait_in;
         img_ff   <= img_in;
         cap_ff   <= cap_in;
         ok_ff    <= ok_in;
         high_ff  <= high_in;
      end
   end

endmodule

@@ rtl/scif_tx.sv @@
// Result register and serialiser: turns one burst into its result items.
// Depends on scif_pkg.
module scif_tx import scif_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        load,
   input  desc_type    desc,
   output logic        free,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_out_kind,
   output logic [7:0]  rsp_out_byte,
   output logic [14:0] rsp_image_offset,
   output logic [14:0] rsp_image_bytes,
   output logic [9:0]  rsp_captured_total,
   output logic        rsp_last
);

   desc_type   desc_ff;
   logic       busy_ff, busy_in;
   logic [2:0] beat_ff, beat_in;
   logic       last_beat;

   assign rsp_valid = busy_ff;
   assign rsp_last  = last_beat;
   assign free      = !busy_ff || (rsp_ready && last_beat);

   always_comb begin
      rsp_out_kind       = KIND_CMD;
      rsp_out_byte       = NUL_BYTE;
      rsp_image_offset   = 15'd0;
      rsp_image_bytes    = 15'd0;
      rsp_captured_total = 10'd0;
      last_beat          = 1'b1;
      case (desc_ff.burst)
         BURST_SNAP: begin
            last_beat = (beat_ff == 3'd6);
            case (beat_ff)
               3'd0:    rsp_out_byte = SYNC_BYTE;
               3'd1:    rsp_out_byte = SNAP_CMD;
               3'd2:    rsp_out_byte = desc_ff.camera_id;
               3'd3:    rsp_out_byte = desc_ff.resolution_code;
               3'd4:    rsp_out_byte = NUL_BYTE;
               3'd5:    rsp_out_byte = SNAP_ARG;
               default: rsp_out_byte = TAIL_BYTE;
            endcase
         end
         BURST_REQ: begin
            last_beat = (beat_ff == 3'd5);
            case (beat_ff)
               3'd0:    rsp_out_byte = SYNC_BYTE;
               3'd1:    rsp_out_byte = PKG_CMD;
               3'd2:    rsp_out_byte = desc_ff.camera_id;
               3'd3:    rsp_out_byte = desc_ff.number[7:0];
               3'd4:    rsp_out_byte = desc_ff.number[15:8];
               default: rsp_out_byte = TAIL_BYTE;
            endcase
         end
         BURST_IMAGE: begin
            rsp_out_kind     = KIND_IMAGE;
            rsp_out_byte     = desc_ff.data;
            rsp_image_offset = desc_ff.offset;
         end
         BURST_DONE: begin
            rsp_out_kind       = KIND_DONE;
            rsp_image_bytes    = desc_ff.size;
            rsp_captured_total = desc_ff.total;
         end
         BURST_FAIL: rsp_out_kind = KIND_FAIL;
         default: ;
      endcase
   end

   always_comb begin
      busy_in = busy_ff;
      beat_in = beat_ff;
      if (load) begin
         busy_in = 1'b1;
         beat_in = 3'd0;
      end else if (busy_ff && rsp_ready) begin
         if (last_beat) begin
            busy_in = 1'b0;
         end else begin
            beat_in = beat_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         desc_ff <= desc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         beat_ff <= 3'd0;
      end else begin
         busy_ff <= busy_in;
         beat_ff <= beat_in;
      end
   end

endmodule

@@ rtl/serial_camera_image_fetch_unit.sv @@
// Top level of the serial camera image fetch unit: input register, sequencer,
// serialiser and register file. Depends on scif_pkg, scif_csr, scif_core, scif_tx.
//
//  channel  | signals                                   | direction
//  ---------+-------------------------------------------+----------
//  req      | req_valid/ready, operation, rx_byte       | in
//  rsp      | rsp_valid/ready, kind, byte, offset, ...  | out
//  csr      | psel, penable, pwrite, paddr, pwdata, ... | in/out
//
// One item per cycle enters the input register while req_ready is high; the
// sequencer works on it in the next cycle. Items that cause no result (ticks,
// most received bytes) retire at one a cycle. Items that cause results occupy
// the result register until their last result is taken: 7 results for a snapshot
// command, 6 for a package request, 1 otherwise; the serialiser sets that figure.
// Reset is synchronous, active high, and returns the capture to idle.
// A stall on rsp holds the result register; the input register then holds its
// item only if that item has results of its own.
`include "serial_camera_image_fetch_unit_assert.svh"

module serial_camera_image_fetch_unit import scif_pkg::*; #(
   parameter int PAYLOAD_BYTES   = 1024,
   parameter int MAX_IMAGE_BYTES = 32768,
   parameter int COUNT_WRAP      = 1000
) (
   input  logic        clock,
   input  logic        reset,
   // item input
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_operation,
   input  logic [7:0]  req_rx_byte,
   // result output
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_out_kind,
   output logic [7:0]  rsp_out_byte,
   output logic [14:0] rsp_image_offset,
   output logic [14:0] rsp_image_bytes,
   output logic [9:0]  rsp_captured_total,
   output logic        rsp_last,
   // register port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   // input register
   logic       in_vld_ff, in_vld_in;
   logic [1:0] op_ff;
   logic [7:0] byte_ff;

   cfg_type  cfg;
   desc_type desc;
   logic     tx_free;
   logic     no_result;
   logic     advance;
   logic     load;
   logic     req_fire;

   // an item with no result retires even while the serialiser is busy
   assign no_result = (desc.burst == BURST_NONE);
   assign advance   = in_vld_ff && (no_result || tx_free);
   assign load      = advance && !no_result;
   assign req_ready = !in_vld_ff || advance;
   assign req_fire  = req_valid && req_ready;
   assign in_vld_in = req_fire || (in_vld_ff && !advance);

   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff   <= req_operation;
         byte_ff <= req_rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   scif_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   scif_core #(
      .PAYLOAD_BYTES   (PAYLOAD_BYTES),
      .MAX_IMAGE_BYTES (MAX_IMAGE_BYTES),
      .COUNT_WRAP      (COUNT_WRAP)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .operation (op_ff),
      .rx_byte   (byte_ff),
      .cfg       (cfg),
      .desc      (desc)
   );

   scif_tx u_tx (
      .clock              (clock),
      .reset              (reset),
      .load               (load),
      .desc               (desc),
      .free               (tx_free),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_out_kind       (rsp_out_kind),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_image_offset   (rsp_image_offset),
      .rsp_image_bytes    (rsp_image_bytes),
      .rsp_captured_total (rsp_captured_total),
      .rsp_last           (rsp_last)
   );

   // a held input item always means a result is waiting
   `SCIF_ASSERT_NOW(a_stall_has_cause, clock, reset, !req_ready, rsp_valid)
   // single results (image, done, failed) are always the last of their item
   `SCIF_ASSERT_NOW(a_single_is_last, clock, reset,
      rsp_valid && rsp_out_kind != KIND_CMD, rsp_last)
   // a burst handed to the serialiser shows up on the result port next cycle
   `SCIF_ASSERT_NEXT(a_load_shows, clock, reset, load, rsp_valid)

endmodule
